### sv/olb_pkg.sv
// shared types and constants for the ordered list buffer
package olb_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_APPEND = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef struct packed {
        logic load_prev;
        logic load_val;
    } cell_ctl_t;

endpackage

### sv/olb_cell.sv
// one list slot: loads a new value or takes its lower neighbor's value
module olb_cell
    import olb_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] prev_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.load_val) begin
            data_next = wr_data;
        end else if (ctl.load_prev) begin
            data_next = prev_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/ordered_list_buffer_core.sv
// top level of the ordered list buffer: command decode, row of slot cells, result register
//
// channel | dir | tdata (low bit up)                       | tuser
// s_      | in  | position[5:0], value[31:0], zero pad      | mode[2:0]
// m_      | out | ok, read_value[31:0], count[6:0], empty   | -
//
// one beat per cycle unless the output stalls: each command is decoded and applied to the
// cell row in the cycle it is taken, and an insert moves all later slots up in that same cycle
// result appears in the cycle after the command beat, from a single output register
// s_tready follows the output register: a stalled result holds the input off
// reset clears the element count and the output valid; slot contents stay undefined
module ordered_list_buffer_core
    import olb_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position[5:0], value[37:6], pad
    input  logic [MODE_W-1:0]   s_tuser,   // mode[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // ok, read_value[32:1], count[39:33], empty[40], pad
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              m_valid_reg, m_valid_next;
    logic              ok_reg, ok_next;
    logic [VALUE_W-1:0] rd_reg, rd_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic              empty_reg, empty_next;

    logic              s_fire;
    mode_t             mode;
    logic [POS_W-1:0]  pos;
    logic [VALUE_W-1:0] value;
    logic [CMP_W-1:0]  pos_c, fill_c;
    logic              pos_ok, not_full;
    logic              get_go, set_go, ins_go, app_go;
    logic [63:0]       val_wide, rd_wide;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    cell_ctl_t             cell_ctl [CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign mode  = mode_t'(s_tuser);
    assign pos   = s_tdata[POS_W-1:0];
    assign value = s_tdata[POS_W+VALUE_W-1:POS_W];

    assign pos_c    = CMP_W'(pos);
    assign fill_c   = CMP_W'(fill_reg);
    assign pos_ok   = pos_c < fill_c;
    assign not_full = fill_c < CMP_W'(CAPACITY);

    assign get_go = s_fire && (mode == MODE_GET) && pos_ok;
    assign set_go = s_fire && (mode == MODE_SET) && pos_ok;
    assign ins_go = s_fire && (mode == MODE_INSERT) && pos_ok && not_full;
    assign app_go = s_fire && (mode == MODE_APPEND) && not_full;

    assign val_wide = {32'b0, value};
    assign wr_data  = val_wide[DATA_WIDTH-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data;
            if (gi == 0) begin : g_first
                assign prev_data = '0;
            end else begin : g_rest
                assign prev_data = cell_q[gi-1];
            end
            assign cell_ctl[gi].load_prev = ins_go && (CMP_W'(gi) > pos_c);
            assign cell_ctl[gi].load_val  = ((set_go || ins_go) && (CMP_W'(gi) == pos_c))
                                         || (app_go && (CMP_W'(gi) == fill_c));
            olb_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .aclk     (aclk),
                .ctl      (cell_ctl[gi]),
                .wr_data  (wr_data),
                .prev_data(prev_data),
                .data     (cell_q[gi])
            );
        end
    endgenerate

    assign rd_data = cell_q[pos_c[IDX_W-1:0]];
    assign rd_wide = 64'(rd_data);

    always_comb begin
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        rd_next      = rd_reg;
        count_next   = count_reg;
        empty_next   = empty_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next = 1'b1;
            ok_next      = 1'b0;
            rd_next      = '0;
            unique case (mode)
                MODE_GET: begin
                    ok_next = get_go;
                    if (get_go) begin
                        rd_next = rd_wide[VALUE_W-1:0];
                    end
                end
                MODE_SET: begin
                    ok_next = set_go;
                end
                MODE_INSERT: begin
                    ok_next = ins_go;
                    if (ins_go) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                MODE_APPEND: begin
                    ok_next = app_go;
                    if (app_go) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    ok_next   = 1'b1;
                    fill_next = '0;
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
            count_next = COUNT_W'(fill_next);
            empty_next = (fill_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        ok_reg    <= ok_next;
        rd_reg    <= rd_next;
        count_reg <= count_next;
        empty_reg <= empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 1 - VALUE_W - COUNT_W - 1){1'b0}},
                       empty_reg, count_reg, rd_reg, ok_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("element count above capacity");

    a_fill_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(fill_reg))
        else $error("element count changed without a command beat");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mode == MODE_CLEAR) |=> (m_valid_reg && ok_reg && empty_reg
                                            && count_reg == '0))
        else $error("clear did not report an empty list");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !ok_reg) |-> (rd_reg == '0))
        else $error("refused command returned read data");

endmodule

### dv/ordered_list_buffer_core_checker.sv
// list model and result scoreboard for the ordered list buffer channels
module ordered_list_buffer_core_checker
    import olb_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position[5:0], value[37:6], pad
    input  logic [MODE_W-1:0]   s_tuser,   // mode[2:0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // ok, read_value[32:1], count[39:33], empty[40], pad
    output int                  fail_count,
    output int                  pending,
    output int                  list_len
);

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } list_result_t;

    logic [VALUE_W-1:0] slot_mem [CAPACITY];
    int                 fill_len = 0;
    int                 errors = 0;
    list_result_t       result_q [$];

    assign fail_count = errors;
    assign pending    = result_q.size();
    assign list_len   = fill_len;

    function automatic int field_mismatch(string name, logic [VALUE_W-1:0] exp_v,
                                          logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : monitor
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        list_result_t       res;
        list_result_t       exp_r;
        list_result_t       got;
        int                 k;
        if (!aresetn) begin
            fill_len = 0;
            result_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                mode = s_tuser;
                pos  = s_tdata[POS_W-1:0];
                val  = s_tdata[POS_W +: VALUE_W];
                res  = '0;
                case (mode)
                    MODE_GET: begin
                        if (pos < fill_len) begin
                            res.read_value = slot_mem[pos];
                            res.ok = 1'b1;
                        end
                    end
                    MODE_SET: begin
                        if (pos < fill_len) begin
                            slot_mem[pos] = val;
                            res.ok = 1'b1;
                        end
                    end
                    MODE_INSERT: begin
                        if (pos < fill_len && fill_len < CAPACITY) begin
                            for (k = fill_len; k > pos; k--)
                                slot_mem[k] = slot_mem[k-1];
                            slot_mem[pos] = val;
                            fill_len++;
                            res.ok = 1'b1;
                        end
                    end
                    MODE_APPEND: begin
                        if (fill_len < CAPACITY) begin
                            slot_mem[fill_len] = val;
                            fill_len++;
                            res.ok = 1'b1;
                        end
                    end
                    MODE_CLEAR: begin
                        fill_len = 0;
                        res.ok = 1'b1;
                    end
                    default: ;
                endcase
                res.count = fill_len[COUNT_W-1:0];
                res.empty = (fill_len == 0);
                result_q.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                got.ok         = m_tdata[0];
                got.read_value = m_tdata[VALUE_W:1];
                got.count      = m_tdata[VALUE_W+COUNT_W:VALUE_W+1];
                got.empty      = m_tdata[VALUE_W+COUNT_W+1];
                if (result_q.size() == 0) begin
                    $error("result beat with no command outstanding");
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    errors += field_mismatch("ok", exp_r.ok, got.ok)
                            + field_mismatch("read_value", exp_r.read_value, got.read_value)
                            + field_mismatch("count", exp_r.count, got.count)
                            + field_mismatch("empty_res", exp_r.empty, got.empty);
                end
            end
        end
    end

endmodule

### dv/ordered_list_buffer_core_tb.sv
// stimulus, handshake pacing and verdict for the ordered list buffer core
module ordered_list_buffer_core_tb;
    import olb_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int RAND_ITEMS = 1850;
    localparam int IDLE_LIMIT = 1000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // position[5:0], value[37:6], pad
    logic [MODE_W-1:0]   s_tuser;   // mode[2:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // ok, read_value[32:1], count[39:33], empty[40], pad

    int   fail_count;
    int   pending;
    int   list_len;
    int   idle_cycles = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;

    always #5 aclk = ~aclk;

    ordered_list_buffer_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordered_list_buffer_core_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len)
    );

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // mostly positions inside the list, the rest anywhere
    function automatic logic [POS_W-1:0] pick_pos(int len);
        if (len > 0 && $urandom_range(0, 99) < 80)
            return POS_W'($urandom_range(0, len - 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // kind 0 grow, 1 mixed, 2 read back, 3 noise
    function automatic logic [MODE_W-1:0] pick_mode(int kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            0: begin
                if (r < 40) return MODE_APPEND;
                if (r < 70) return MODE_INSERT;
                if (r < 85) return MODE_GET;
                if (r < 95) return MODE_SET;
                if (r < 96) return MODE_CLEAR;
            end
            1: begin
                if (r < 25) return MODE_GET;
                if (r < 50) return MODE_SET;
                if (r < 70) return MODE_INSERT;
                if (r < 90) return MODE_APPEND;
                if (r < 95) return MODE_CLEAR;
            end
            2: begin
                if (r < 50) return MODE_GET;
                if (r < 80) return MODE_SET;
                if (r < 88) return MODE_INSERT;
                if (r < 96) return MODE_APPEND;
                if (r < 98) return MODE_CLEAR;
            end
            default: return MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
        endcase
        return MODE_W'($urandom_range(MODE_CLEAR + 1, (1 << MODE_W) - 1));
    endfunction

    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-POS_W-VALUE_W){1'b0}}, val, pos};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet)
                stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("ordered_list_buffer_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int seg_len;
        int kind;
        int i;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list: reads, writes and inserts are refused
        send_cmd(MODE_GET,    6'd0,  32'hffff_ffff);
        send_cmd(MODE_SET,    6'd0,  32'hffff_ffff);
        send_cmd(MODE_INSERT, 6'd0,  32'h1111_1111);
        send_cmd(MODE_GET,    6'd63, 32'h0);
        send_cmd(MODE_APPEND, 6'd63, 32'hffff_ffff);
        send_cmd(MODE_APPEND, 6'd0,  32'h0);
        send_cmd(MODE_INSERT, 6'd0,  32'h1234_5678);
        send_cmd(MODE_INSERT, 6'd1,  32'ha5a5_a5a5);
        // insert at the current length is past the end
        send_cmd(MODE_INSERT, 6'd4,  32'h5a5a_5a5a);
        for (i = 0; i < 4; i++)
            send_cmd(MODE_GET, i[POS_W-1:0], 32'h0);
        send_cmd(MODE_SET,    6'd3,  32'hdead_beef);
        send_cmd(MODE_SET,    6'd63, 32'hffff_ffff);
        send_cmd(MODE_GET,    6'd3,  32'hffff_ffff);
        send_cmd(MODE_GET,    6'd63, 32'hffff_ffff);
        // unused modes
        send_cmd(3'd5, 6'd0,  32'hffff_ffff);
        send_cmd(3'd6, 6'd1,  32'h0);
        send_cmd(3'd7, 6'd63, 32'hffff_ffff);
        send_cmd(MODE_CLEAR,  6'd63, 32'hffff_ffff);
        send_cmd(MODE_GET,    6'd0,  32'h0);
        send_cmd(MODE_CLEAR,  6'd0,  32'h0);
        send_cmd(MODE_APPEND, 6'd0,  32'h0000_0001);

        sent = 0;
        while (sent < RAND_ITEMS) begin
            seg_len = $urandom_range(40, 120);
            kind    = $urandom_range(0, 3);
            quiet   = ($urandom_range(0, 4) == 0);
            if (kind == 0 && $urandom_range(0, 1) == 1) begin
                send_cmd(MODE_CLEAR, pick_pos(list_len), pick_value());
                sent++;
            end
            for (i = 0; i < seg_len; i++) begin
                send_cmd(pick_mode(kind), pick_pos(list_len), pick_value());
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("ordered_list_buffer_core verification clean");
        else
            $display("ordered_list_buffer_core verification failed");
        $finish;
    end

endmodule
